// ----- sv/bht_pkg.sv -----
// ----------------------------------------------------------------------------
// bht_pkg
// Shared sizes, codes and types for the bucketed hash table.
// ----------------------------------------------------------------------------
package bht_pkg;

  localparam int BUCKETS = 16;
  localparam int WAYS    = 4;

  localparam int KEY_W    = 31;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int OUT_COUNT_W = 7;

  localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SLOTS    = BUCKETS * WAYS;
  localparam int COUNT_W  = $clog2(SLOTS + 1);

  // A power-of-two bucket count hashes by taking the low key bits.
  localparam bit BUCKET_POW2 = ((1 << BUCKET_W) == BUCKETS);

  // Otherwise divide by reciprocal multiplication: the quotient is exact for
  // every key below 2**KEY_W, and only its low BUCKET_W bits are needed.
  localparam int HASH_SHIFT = KEY_W + BUCKET_W;
  localparam logic [KEY_W:0] HASH_RECIP =
    (KEY_W + 1)'(((64'd1 << HASH_SHIFT) / 64'(BUCKETS)) + 64'd1);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_READ,
    S_UPDATE
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } slot_t;

  typedef slot_t [WAYS-1:0] row_t;

endpackage

// ----- sv/bucketed_hash_table.sv -----
// ----------------------------------------------------------------------------
// bucketed_hash_table
// Key-value table hashed by key mod BUCKETS, WAYS slots per bucket.
// ----------------------------------------------------------------------------
// Pulse start with command, key and value while busy is low; the beat is taken
// at that edge. Every command gives exactly one result: done is high for one
// cycle with status and entry_count, and the receiver cannot stall it. The
// key/value slots of a bucket sit in one memory row that is read, compared
// across all ways at once and written back. With a power-of-two bucket count
// a command runs the memory read, then compare and write-back, and the
// next one may start while the result is shown. Otherwise the bucket index
// comes from a reciprocal multiplication in an extra hash state, followed by
// a read state, before compare and write-back. Slot valid bits are flip-flops
// cleared at reset, so no clearing pass is needed.
module bucketed_hash_table (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           command,
  input  logic [bht_pkg::KEY_W-1:0]      key,
  input  logic signed [bht_pkg::VALUE_W-1:0] value,
  output logic                           done,
  output logic [bht_pkg::STATUS_W-1:0]   status,
  output logic [bht_pkg::OUT_COUNT_W-1:0] entry_count
);

  bht_pkg::state_t state, state_next;

  logic                            cmd_q;
  logic [bht_pkg::KEY_W-1:0]       key_q;
  logic [bht_pkg::VALUE_W-1:0]     value_q;
  logic [bht_pkg::BUCKET_W-1:0]    bucket;
  logic [bht_pkg::BUCKET_W-1:0]    quot;
  logic [bht_pkg::BUCKET_W-1:0]    hash_bucket;
  logic [2*bht_pkg::KEY_W:0]       hash_prod;
  logic [bht_pkg::COUNT_W-1:0]     live;

  logic [bht_pkg::WAYS-1:0]        valid_rows [bht_pkg::BUCKETS];
  bht_pkg::row_t                   row_mem    [bht_pkg::BUCKETS];
  bht_pkg::row_t                   row_rd;
  bht_pkg::row_t                   row_new;

  logic                            accept;
  logic                            rd_en;
  logic [bht_pkg::BUCKET_W-1:0]    rd_addr;
  logic                            wr_en;

  logic [bht_pkg::WAYS-1:0]        valid_cur;
  logic [bht_pkg::WAYS-1:0]        hit_vec;
  logic [bht_pkg::WAYS-1:0]        free_vec;
  logic [bht_pkg::WAYS-1:0]        valid_new;
  logic                            hit;
  logic                            has_free;
  bht_pkg::status_t                status_new;
  logic [bht_pkg::COUNT_W-1:0]     live_new;

  assign accept = start && !busy;

  // ---- control --------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bht_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    rd_en      = 1'b0;
    rd_addr    = bucket;
    wr_en      = 1'b0;
    unique case (state)
      bht_pkg::S_IDLE: begin
        busy    = 1'b0;
        rd_addr = key[bht_pkg::BUCKET_W-1:0];
        if (accept) begin
          if (bht_pkg::BUCKET_POW2) begin
            rd_en      = 1'b1;
            state_next = bht_pkg::S_UPDATE;
          end else begin
            state_next = bht_pkg::S_HASH;
          end
        end
      end
      bht_pkg::S_HASH: begin
        state_next = bht_pkg::S_READ;
      end
      bht_pkg::S_READ: begin
        rd_en      = 1'b1;
        rd_addr    = hash_bucket;
        state_next = bht_pkg::S_UPDATE;
      end
      bht_pkg::S_UPDATE: begin
        wr_en      = 1'b1;
        state_next = bht_pkg::S_IDLE;
      end
      default: state_next = bht_pkg::S_IDLE;
    endcase
  end

  // ---- bucket index by reciprocal multiplication ------------------------------
  assign hash_prod = (2*bht_pkg::KEY_W+1)'(key_q) *
                     (2*bht_pkg::KEY_W+1)'(bht_pkg::HASH_RECIP);
  // The remainder is below BUCKETS, so the low bits of key - q*BUCKETS suffice.
  assign hash_bucket = key_q[bht_pkg::BUCKET_W-1:0] -
                       bht_pkg::BUCKET_W'(quot * bht_pkg::BUCKETS);

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= command;
      key_q   <= key;
      value_q <= value;
      bucket  <= key[bht_pkg::BUCKET_W-1:0];
    end else if (state == bht_pkg::S_HASH) begin
      quot    <= hash_prod[bht_pkg::HASH_SHIFT +: bht_pkg::BUCKET_W];
    end else if (state == bht_pkg::S_READ) begin
      bucket  <= hash_bucket;
    end
  end

  // ---- slot memory --------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem[bucket] <= row_new;
    end
    if (rd_en) begin
      row_rd <= row_mem[rd_addr];
    end
  end

  // ---- compare across ways and build the write-back row ----------------------
  always_comb begin
    valid_cur = valid_rows[bucket];
    for (int w = 0; w < bht_pkg::WAYS; w++) begin
      hit_vec[w] = valid_cur[w] && (row_rd[w].key == key_q);
    end
    hit      = |hit_vec;
    // lowest clear valid bit
    free_vec = ~valid_cur & (valid_cur + 1'b1);
    has_free = |free_vec;

    row_new    = row_rd;
    valid_new  = valid_cur;
    live_new   = live;
    status_new = bht_pkg::ST_NOT_FOUND;

    if (cmd_q == bht_pkg::CMD_INSERT) begin
      if (hit) begin
        status_new = bht_pkg::ST_UPDATED;
        for (int w = 0; w < bht_pkg::WAYS; w++) begin
          if (hit_vec[w]) begin
            row_new[w].value = value_q;
          end
        end
      end else if (has_free) begin
        status_new = bht_pkg::ST_INSERTED;
        valid_new  = valid_cur | free_vec;
        live_new   = live + 1'b1;
        for (int w = 0; w < bht_pkg::WAYS; w++) begin
          if (free_vec[w]) begin
            row_new[w].key   = key_q;
            row_new[w].value = value_q;
          end
        end
      end else begin
        status_new = bht_pkg::ST_FULL;
      end
    end else begin
      if (hit) begin
        status_new = bht_pkg::ST_REMOVED;
        valid_new  = valid_cur & ~hit_vec;
        if (live != '0) begin
          live_new = live - 1'b1;
        end
      end
    end
  end

  // ---- valid bits, count and result beat ------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < bht_pkg::BUCKETS; b++) begin
        valid_rows[b] <= '0;
      end
      live <= '0;
      done <= 1'b0;
    end else begin
      done <= wr_en;
      if (wr_en) begin
        valid_rows[bucket] <= valid_new;
        live               <= live_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      status      <= status_new;
      entry_count <= bht_pkg::OUT_COUNT_W'(live_new);
    end
  end

endmodule
